[hw/rtl/bxds_pkg.sv]
// Shared types, constants and a helper function for the box-average downscaler.
package bxds_pkg;

    localparam int unsigned MAX_WIDTH_DEF  = 1024;
    localparam int unsigned MAX_FACTOR_DEF = 16;
    localparam int unsigned MAX_HEIGHT     = 4096;

    localparam int unsigned CH_W       = 8;
    localparam int unsigned NUM_CH     = 3;
    localparam int unsigned IMG_W_W    = 11;
    localparam int unsigned IMG_H_W    = 13;
    localparam int unsigned FACTOR_W   = 5;
    localparam int unsigned CFG_DATA_W = 13;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned ROW_W      = 12;
    localparam int unsigned ROW_CMP_W  = 14;

    localparam logic [IMG_W_W-1:0]  IMG_W_RST  = IMG_W_W'(640);
    localparam logic [IMG_H_W-1:0]  IMG_H_RST  = IMG_H_W'(480);
    localparam logic [FACTOR_W-1:0] FACTOR_RST = FACTOR_W'(2);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH  = 2'd0,
        CFG_IMAGE_HEIGHT = 2'd1,
        CFG_SCALE_FACTOR = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic [CH_W-1:0] pixel_blue;
        logic [CH_W-1:0] pixel_green;
        logic [CH_W-1:0] pixel_red;
    } pix_in_t;

    typedef struct packed {
        logic [CH_W-1:0] avg_blue;
        logic [CH_W-1:0] avg_green;
        logic [CH_W-1:0] avg_red;
        logic            frame_last;
    } avg_out_t;

    // ceil(2^k / d), bit-serial restoring division; only evaluated at elaboration
    function automatic logic [63:0] recip_ceil(input int unsigned k, input int unsigned d);
        logic [63:0] q;
        logic [64:0] r;
        q = '0;
        r = '0;
        if (d == 0)
        begin
            return '0;
        end
        for (int i = 63; i >= 0; i--)
        begin
            r = {r[63:0], (i == int'(k))};
            q = {q[62:0], 1'b0};
            if (r >= 65'(d))
            begin
                r    = r - 65'(d);
                q[0] = 1'b1;
            end
        end
        if (r != '0)
        begin
            q = q + 64'd1;
        end
        return q;
    endfunction

endpackage

[hw/rtl/box_average_image_downscaler_top.sv]
// Top level of the box-average image downscaler: line store, accumulate and divide pipeline.
// A block's last pixel enters s1; its result then passes the s2, s3 and output registers.
// One pixel per clock unless stalled; the column-sum store is read and written once per cycle,
// with the previous write forwarded when consecutive pixels hit the same column entry.
// Division by factor squared is a multiply by a table reciprocal, one stage after the sum.
// Reset: registers return to 640 x 480, factor 2, position counters and pipeline cleared;
// the column-sum store is not cleared (each block's first pixel overwrites its entry).
module box_average_image_downscaler_top #(
    parameter int unsigned MAX_WIDTH  = bxds_pkg::MAX_WIDTH_DEF,
    parameter int unsigned MAX_FACTOR = bxds_pkg::MAX_FACTOR_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [bxds_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [bxds_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  bxds_pkg::pix_in_t                   in_data,
    output logic                                out_valid,
    input  logic                                out_stall,
    output bxds_pkg::avg_out_t                  out_data
);

    localparam int unsigned AW    = $clog2(MAX_WIDTH);
    localparam int unsigned WE_W  = $clog2(MAX_WIDTH + 1);
    localparam int unsigned FB    = $clog2(MAX_FACTOR);
    localparam int unsigned F_W   = $clog2(MAX_FACTOR + 1);
    localparam int unsigned PH_W  = FB;
    localparam int unsigned SUM_W = bxds_pkg::CH_W + 2 * FB;
    localparam int unsigned MEM_W = bxds_pkg::NUM_CH * SUM_W;
    localparam int unsigned K     = SUM_W + 2 * FB;
    localparam int unsigned RC_W  = K + 1;
    localparam int unsigned PR_W  = SUM_W + RC_W;
    localparam int unsigned CW    = ((WE_W > F_W) ? WE_W : F_W) + 1;
    localparam int unsigned RW    = bxds_pkg::ROW_CMP_W;
    localparam int unsigned CH_W  = bxds_pkg::CH_W;
    localparam int unsigned NCH   = bxds_pkg::NUM_CH;

    // configuration
    logic [bxds_pkg::IMG_W_W-1:0]  width_reg;
    logic [bxds_pkg::IMG_H_W-1:0]  height_reg;
    logic [bxds_pkg::FACTOR_W-1:0] factor_reg;
    logic [WE_W-1:0]               w_eff;
    logic [bxds_pkg::IMG_H_W-1:0]  h_eff;
    logic [F_W-1:0]                f_eff;
    logic [F_W-1:0]                f_m1;

    // position counters
    logic [AW-1:0]                 in_col_reg, in_col_next;
    logic [bxds_pkg::ROW_W-1:0]    in_row_reg, in_row_next;
    logic [PH_W-1:0]               col_phase_reg, col_phase_next;
    logic [PH_W-1:0]               row_phase_reg, row_phase_next;
    logic [AW-1:0]                 out_col_reg, out_col_next;

    logic in_acc;
    logic col_ok, row_ok, col_end, row_end, last_col, last_row;
    logic line_end, frame_end, blk_first, blk_emit;

    // accumulate stage
    logic                 s1_valid_reg, s1_valid_next;
    logic                 s1_wr_reg, s1_emit_reg, s1_first_reg, s1_last_reg, s1_fwd_reg;
    logic [AW-1:0]        s1_addr_reg;
    bxds_pkg::pix_in_t    s1_px_reg;
    logic                 s1_adv, s1_we;
    logic [MEM_W-1:0]     s1_base, s1_sum;
    logic [CH_W-1:0]      s1_px [NCH];

    logic [MEM_W-1:0]     mem [MAX_WIDTH];
    logic [MEM_W-1:0]     rd_data_reg;
    logic [MEM_W-1:0]     wr_data_reg;

    // divide stages
    logic                 s2_valid_reg, s2_last_reg, s2_adv;
    logic [MEM_W-1:0]     s2_sum_reg;
    logic [RC_W-1:0]      recip_tab [MAX_FACTOR + 1];
    logic [RC_W-1:0]      recip_reg;
    logic                 s3_valid_reg, s3_last_reg, s3_adv;
    logic [PR_W-1:0]      s3_prod_reg [NCH];
    logic                 out_valid_reg;
    bxds_pkg::avg_out_t   out_data_reg;

    for (genvar g = 0; g <= MAX_FACTOR; g++)
    begin : g_recip
        assign recip_tab[g] = RC_W'(bxds_pkg::recip_ceil(K, g * g));
    end

    // ---------------------------------------------------------------- config
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= bxds_pkg::IMG_W_RST;
            height_reg <= bxds_pkg::IMG_H_RST;
            factor_reg <= bxds_pkg::FACTOR_RST;
        end
        else if (cfg_we)
        begin
            case (bxds_pkg::cfg_reg_t'(cfg_index))
                bxds_pkg::CFG_IMAGE_WIDTH:  width_reg  <= cfg_data[bxds_pkg::IMG_W_W-1:0];
                bxds_pkg::CFG_IMAGE_HEIGHT: height_reg <= cfg_data[bxds_pkg::IMG_H_W-1:0];
                bxds_pkg::CFG_SCALE_FACTOR: factor_reg <= cfg_data[bxds_pkg::FACTOR_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        if (width_reg == '0)
            w_eff = WE_W'(1);
        else if (32'(width_reg) > MAX_WIDTH)
            w_eff = WE_W'(MAX_WIDTH);
        else
            w_eff = WE_W'(width_reg);

        if (height_reg == '0)
            h_eff = bxds_pkg::IMG_H_W'(1);
        else if (32'(height_reg) > bxds_pkg::MAX_HEIGHT)
            h_eff = bxds_pkg::IMG_H_W'(bxds_pkg::MAX_HEIGHT);
        else
            h_eff = height_reg;

        if (factor_reg == '0)
            f_eff = F_W'(1);
        else if (32'(factor_reg) > MAX_FACTOR)
            f_eff = F_W'(MAX_FACTOR);
        else
            f_eff = F_W'(factor_reg);
    end

    assign f_m1 = f_eff - F_W'(1);

    // ---------------------------------------------------------- block tracking
    assign in_acc = in_valid && !in_stall;

    // a block counts only if it fits wholly inside the frame
    assign col_ok    = (CW'(in_col_reg) - CW'(col_phase_reg) + CW'(f_eff)) <= CW'(w_eff);
    assign row_ok    = (RW'(in_row_reg) - RW'(row_phase_reg) + RW'(f_eff)) <= RW'(h_eff);
    assign col_end   = col_phase_reg == PH_W'(f_m1);
    assign row_end   = row_phase_reg == PH_W'(f_m1);
    assign last_col  = (CW'(in_col_reg) + CW'(f_eff)) >= CW'(w_eff);
    assign last_row  = (RW'(in_row_reg) + RW'(f_eff)) >= RW'(h_eff);
    assign line_end  = (CW'(in_col_reg) + CW'(1)) >= CW'(w_eff);
    assign frame_end = (RW'(in_row_reg) + RW'(1)) >= RW'(h_eff);
    assign blk_first = (col_phase_reg == '0) && (row_phase_reg == '0);
    assign blk_emit  = col_ok && row_ok && col_end && row_end;

    always_comb
    begin
        in_col_next    = in_col_reg;
        in_row_next    = in_row_reg;
        col_phase_next = col_phase_reg;
        row_phase_next = row_phase_reg;
        out_col_next   = out_col_reg;
        if (cfg_we)
        begin
            in_col_next    = '0;
            in_row_next    = '0;
            col_phase_next = '0;
            row_phase_next = '0;
            out_col_next   = '0;
        end
        else if (in_acc)
        begin
            if (col_end)
            begin
                col_phase_next = '0;
                out_col_next   = out_col_reg + AW'(1);
            end
            else
            begin
                col_phase_next = col_phase_reg + PH_W'(1);
            end
            in_col_next = in_col_reg + AW'(1);
            if (line_end)
            begin
                in_col_next    = '0;
                col_phase_next = '0;
                out_col_next   = '0;
                row_phase_next = row_end ? '0 : row_phase_reg + PH_W'(1);
                in_row_next    = frame_end ? '0 : in_row_reg + bxds_pkg::ROW_W'(1);
                if (frame_end)
                    row_phase_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg    <= '0;
            in_row_reg    <= '0;
            col_phase_reg <= '0;
            row_phase_reg <= '0;
            out_col_reg   <= '0;
        end
        else
        begin
            in_col_reg    <= in_col_next;
            in_row_reg    <= in_row_next;
            col_phase_reg <= col_phase_next;
            row_phase_reg <= row_phase_next;
            out_col_reg   <= out_col_next;
        end
    end

    // ---------------------------------------------------------- accumulate
    assign s1_adv   = s1_valid_reg && (!s1_emit_reg || !s2_valid_reg || s2_adv);
    assign s1_we    = s1_adv && s1_wr_reg;
    assign in_stall = s1_valid_reg && !s1_adv;

    assign s1_px[0] = s1_px_reg.pixel_blue;
    assign s1_px[1] = s1_px_reg.pixel_green;
    assign s1_px[2] = s1_px_reg.pixel_red;

    // entry written at the same edge as our read is not yet in rd_data_reg
    assign s1_base = s1_fwd_reg ? wr_data_reg : rd_data_reg;

    always_comb
    begin
        for (int c = 0; c < NCH; c++)
        begin
            s1_sum[c*SUM_W +: SUM_W] = s1_first_reg ? SUM_W'(s1_px[c])
                : s1_base[c*SUM_W +: SUM_W] + SUM_W'(s1_px[c]);
        end
    end

    assign s1_valid_next = in_acc ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_wr_reg    <= col_ok && row_ok;
            s1_emit_reg  <= blk_emit;
            s1_first_reg <= blk_first;
            s1_last_reg  <= last_col && last_row;
            s1_fwd_reg   <= s1_we && (s1_addr_reg == out_col_reg);
            s1_addr_reg  <= out_col_reg;
            s1_px_reg    <= in_data;
        end
        if (s1_we)
            wr_data_reg <= s1_sum;
    end

    // column-sum line store
    always_ff @(posedge clk)
    begin
        if (s1_we)
            mem[s1_addr_reg] <= s1_sum;
        if (in_acc)
            rd_data_reg <= mem[out_col_reg];
    end

    // ---------------------------------------------------------- divide
    assign s2_adv = s2_valid_reg && (!s3_valid_reg || s3_adv);
    assign s3_adv = s3_valid_reg && (!out_valid_reg || !out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_adv && s1_emit_reg)
                s2_valid_reg <= 1'b1;
            else if (s2_adv)
                s2_valid_reg <= 1'b0;

            if (s2_adv)
                s3_valid_reg <= 1'b1;
            else if (s3_adv)
                s3_valid_reg <= 1'b0;

            if (s3_adv)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        recip_reg <= recip_tab[f_eff];
        if (s1_adv && s1_emit_reg)
        begin
            s2_sum_reg  <= s1_sum;
            s2_last_reg <= s1_last_reg;
        end
        if (s2_adv)
        begin
            for (int c = 0; c < NCH; c++)
            begin
                s3_prod_reg[c] <= PR_W'(s2_sum_reg[c*SUM_W +: SUM_W]) * PR_W'(recip_reg);
            end
            s3_last_reg <= s2_last_reg;
        end
        if (s3_adv)
        begin
            out_data_reg.avg_blue   <= s3_prod_reg[0][K +: CH_W];
            out_data_reg.avg_green  <= s3_prod_reg[1][K +: CH_W];
            out_data_reg.avg_red    <= s3_prod_reg[2][K +: CH_W];
            out_data_reg.frame_last <= s3_last_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

`ifndef NO_ASSERTIONS
    a_col_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        (F_W'(col_phase_reg) < f_eff))
        else $error("column phase beyond block edge");

    a_row_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        (F_W'(row_phase_reg) < f_eff))
        else $error("row phase beyond block edge");

    a_in_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        (WE_W'(in_col_reg) < w_eff))
        else $error("input column beyond frame width");

    a_emit_writes: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_emit_reg) |-> s1_wr_reg)
        else $error("block result from an out-of-frame block");

    a_fwd_after_write: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && s1_we && (s1_addr_reg == out_col_reg)) |=> (s1_valid_reg && s1_fwd_reg))
        else $error("same-entry write not forwarded");
`endif

endmodule

[sim/bxds_checker.sv]
// Checker for the box-average downscaler: tracks configuration, predicts block averages, compares.
module box_average_image_downscaler_checker #(
    parameter int unsigned MAX_WIDTH  = bxds_pkg::MAX_WIDTH_DEF,
    parameter int unsigned MAX_FACTOR = bxds_pkg::MAX_FACTOR_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [bxds_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bxds_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            in_valid,
    input  logic                            in_stall,
    input  bxds_pkg::pix_in_t               in_data,
    input  logic                            out_valid,
    input  logic                            out_stall,
    input  bxds_pkg::avg_out_t              out_data,
    output int                              fail_count,
    output int                              results_owed
);

    localparam int unsigned MAX_PRINTED = 100;

    int unsigned reg_width;
    int unsigned reg_height;
    int unsigned reg_factor;

    int unsigned in_col, in_row, col_phase, row_phase, out_col, out_row;
    int unsigned col_sums [MAX_WIDTH][bxds_pkg::NUM_CH];

    bxds_pkg::avg_out_t block_avg_q [$];

    initial fail_count = 0;
    initial results_owed = 0;

    function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned hi);
        if (v == 0)
        begin
            return 1;
        end
        if (v > hi)
        begin
            return hi;
        end
        return v;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        if (fail_count < MAX_PRINTED)
        begin
            $display("checker: %s: got %0d, expected %0d", what, got, want);
        end
        fail_count = fail_count + 1;
    endtask

    task automatic restart_position();
        in_col    = 0;
        in_row    = 0;
        col_phase = 0;
        row_phase = 0;
        out_col   = 0;
        out_row   = 0;
    endtask

    task automatic accumulate_pixel(input bxds_pkg::pix_in_t p);
        int unsigned w, h, f, nw, nh, area;
        int unsigned px [bxds_pkg::NUM_CH];
        bxds_pkg::avg_out_t avg;
        w  = clamp_dim(reg_width, MAX_WIDTH);
        h  = clamp_dim(reg_height, bxds_pkg::MAX_HEIGHT);
        f  = clamp_dim(reg_factor, MAX_FACTOR);
        nw = w / f;
        nh = h / f;
        px[0] = 32'(p.pixel_blue);
        px[1] = 32'(p.pixel_green);
        px[2] = 32'(p.pixel_red);

        if (out_col < nw && out_row < nh)
        begin
            // first pixel of a block overwrites the column entry
            for (int c = 0; c < bxds_pkg::NUM_CH; c++)
            begin
                if (row_phase == 0 && col_phase == 0)
                begin
                    col_sums[out_col][c] = px[c];
                end
                else
                begin
                    col_sums[out_col][c] = col_sums[out_col][c] + px[c];
                end
            end
            if (row_phase == f - 1 && col_phase == f - 1)
            begin
                area           = f * f;
                avg.avg_blue   = bxds_pkg::CH_W'(col_sums[out_col][0] / area);
                avg.avg_green  = bxds_pkg::CH_W'(col_sums[out_col][1] / area);
                avg.avg_red    = bxds_pkg::CH_W'(col_sums[out_col][2] / area);
                avg.frame_last = (out_col == nw - 1 && out_row == nh - 1);
                block_avg_q.push_back(avg);
            end
        end

        col_phase++;
        if (col_phase >= f)
        begin
            col_phase = 0;
            out_col++;
        end
        in_col++;
        if (in_col >= w)
        begin
            in_col    = 0;
            col_phase = 0;
            out_col   = 0;
            row_phase++;
            if (row_phase >= f)
            begin
                row_phase = 0;
                out_row++;
            end
            in_row++;
            if (in_row >= h)
            begin
                restart_position();
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        bxds_pkg::avg_out_t want;
        if (!rst_n)
        begin
            reg_width  = 32'(bxds_pkg::IMG_W_RST);
            reg_height = 32'(bxds_pkg::IMG_H_RST);
            reg_factor = 32'(bxds_pkg::FACTOR_RST);
            restart_position();
            block_avg_q.delete();
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (block_avg_q.size() == 0)
                begin
                    report_mismatch("unexpected result, packed value", 32'(out_data), 0);
                end
                else
                begin
                    want = block_avg_q.pop_front();
                    if (out_data.avg_blue !== want.avg_blue)
                    begin
                        report_mismatch("avg_blue", 32'(out_data.avg_blue),
                                        32'(want.avg_blue));
                    end
                    if (out_data.avg_green !== want.avg_green)
                    begin
                        report_mismatch("avg_green", 32'(out_data.avg_green),
                                        32'(want.avg_green));
                    end
                    if (out_data.avg_red !== want.avg_red)
                    begin
                        report_mismatch("avg_red", 32'(out_data.avg_red),
                                        32'(want.avg_red));
                    end
                    if (out_data.frame_last !== want.frame_last)
                    begin
                        report_mismatch("frame_last", 32'(out_data.frame_last),
                                        32'(want.frame_last));
                    end
                end
            end

            if (cfg_we)
            begin
                case (cfg_index)
                    bxds_pkg::CFG_IMAGE_WIDTH:
                        reg_width  = 32'(cfg_data[bxds_pkg::IMG_W_W-1:0]);
                    bxds_pkg::CFG_IMAGE_HEIGHT:
                        reg_height = 32'(cfg_data[bxds_pkg::IMG_H_W-1:0]);
                    bxds_pkg::CFG_SCALE_FACTOR:
                        reg_factor = 32'(cfg_data[bxds_pkg::FACTOR_W-1:0]);
                    default: ;
                endcase
                // any write, even to a spare index, starts a new frame
                restart_position();
            end

            if (in_valid && !in_stall)
            begin
                accumulate_pixel(in_data);
            end
        end
        results_owed = block_avg_q.size();
    end

endmodule

[sim/tb_top.sv]
// Testbench top for the box-average downscaler: stimulus, handshake idling and verdict.
module tb_top;

    localparam int RESET_CYCLES  = 10;
    localparam int SETTLE_CYCLES = 6;
    localparam int TAIL_CYCLES   = 10;
    localparam int HOLD_CYCLES   = 400;
    localparam int QUIET_LIMIT   = 3000;
    localparam int RANDOM_PIXELS = 1650;
    localparam logic [bxds_pkg::CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;

    typedef enum int {IDLE_MOSTLY_RX, IDLE_MOSTLY_TX, IDLE_NONE} idle_mode_t;

    logic                            clk       = 1'b0;
    logic                            rst_n     = 1'b0;
    logic                            cfg_we    = 1'b0;
    logic [bxds_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [bxds_pkg::CFG_DATA_W-1:0] cfg_data  = '0;
    logic                            in_valid  = 1'b0;
    logic                            in_stall;
    bxds_pkg::pix_in_t               in_data   = '0;
    logic                            out_valid;
    logic                            out_stall = 1'b0;
    bxds_pkg::avg_out_t              out_data;

    int         fail_count;
    int         results_owed;
    idle_mode_t idle_mode   = IDLE_MOSTLY_RX;
    int         hold_asked  = 0;
    int         hold_served = 0;
    int         quiet       = 0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    box_average_image_downscaler_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    box_average_image_downscaler_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .in_data      (in_data),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_data     (out_data),
        .fail_count   (fail_count),
        .results_owed (results_owed)
    );

    // receiver: random stall, or a long hold-off when the stimulus asks for one
    initial
    begin : receiver
        int unsigned pct;
        forever
        begin
            @(posedge clk);
            if (hold_asked != hold_served)
            begin
                hold_served = hold_served + 1;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            pct = (idle_mode == IDLE_MOSTLY_RX) ? 75 : (idle_mode == IDLE_MOSTLY_TX) ? 16 : 0;
            out_stall <= ($urandom_range(0, 99) < pct);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
        begin
            quiet <= 0;
        end
        else
        begin
            quiet <= quiet + 1;
            if (quiet >= QUIET_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    function automatic bxds_pkg::pix_in_t make_pixel(input int b, input int g, input int r);
        bxds_pkg::pix_in_t p;
        p.pixel_blue  = bxds_pkg::CH_W'(b);
        p.pixel_green = bxds_pkg::CH_W'(g);
        p.pixel_red   = bxds_pkg::CH_W'(r);
        return p;
    endfunction

    function automatic int rand_channel();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
        begin
            return 0;
        end
        if (pick == 1)
        begin
            return 255;
        end
        return $urandom_range(0, 255);
    endfunction

    task automatic send_pixel(input bxds_pkg::pix_in_t p);
        int unsigned pct;
        pct = (idle_mode == IDLE_MOSTLY_RX) ? 16 : (idle_mode == IDLE_MOSTLY_TX) ? 75 : 0;
        while ($urandom_range(0, 99) < pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_data  <= p;
        in_valid <= 1'b1;
        do @(posedge clk); while (in_stall);
    endtask

    // stop offering and wait until every predicted block average has come out
    task automatic settle();
        in_valid <= 1'b0;
        do @(posedge clk); while (results_owed != 0);
    endtask

    task automatic program_frame(input int w, input int h, input int f);
        settle();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= bxds_pkg::CFG_IMAGE_WIDTH;
        cfg_data  <= bxds_pkg::CFG_DATA_W'(w);
        @(posedge clk);
        cfg_index <= bxds_pkg::CFG_IMAGE_HEIGHT;
        cfg_data  <= bxds_pkg::CFG_DATA_W'(h);
        @(posedge clk);
        cfg_index <= bxds_pkg::CFG_SCALE_FACTOR;
        cfg_data  <= bxds_pkg::CFG_DATA_W'(f);
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // write to the unused index: only restarts the frame
    task automatic restart_write();
        settle();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_SPARE_IDX;
        cfg_data  <= bxds_pkg::CFG_DATA_W'($urandom_range(0, 8191));
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    initial
    begin : stimulus
        int random_sent;
        int pick, w, h, f, count, frames;
        random_sent = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // 2x2 block of full-scale pixels
        program_frame(2, 2, 2);
        repeat (4) send_pixel(make_pixel(255, 255, 255));
        // partial block thrown away by a restart, then a block that truncates to zero
        program_frame(2, 2, 2);
        send_pixel(make_pixel(255, 0, 255));
        send_pixel(make_pixel(0, 255, 0));
        send_pixel(make_pixel(255, 255, 255));
        restart_write();
        repeat (3) send_pixel(make_pixel(0, 0, 0));
        send_pixel(make_pixel(3, 3, 3));
        // factor 1 passes pixels through
        program_frame(3, 1, 1);
        send_pixel(make_pixel(255, 0, 255));
        send_pixel(make_pixel(0, 255, 0));
        send_pixel(make_pixel(128, 127, 1));
        // zero registers act as 1
        program_frame(0, 0, 0);
        send_pixel(make_pixel(170, 85, 255));
        send_pixel(make_pixel(85, 170, 0));
        // frame narrower than the block: nothing comes out
        program_frame(1, 3, 2);
        repeat (3) send_pixel(make_pixel(255, 255, 255));
        // width and height above their maxima saturate
        program_frame(2047, 8191, 1);
        send_pixel(make_pixel(1, 2, 4));
        send_pixel(make_pixel(254, 253, 251));
        send_pixel(make_pixel(255, 255, 255));

        // largest block, with a leftover column
        program_frame(17, 16, 31);
        repeat (17 * 16) send_pixel(make_pixel(rand_channel(), rand_channel(), rand_channel()));
        random_sent += 17 * 16;

        // receiver holds off while the sender keeps offering pass-through pixels
        program_frame(8, 64, 1);
        hold_asked <= hold_asked + 1;
        repeat (120) send_pixel(make_pixel(rand_channel(), rand_channel(), rand_channel()));
        random_sent += 120;

        while (random_sent < RANDOM_PIXELS)
        begin
            if (random_sent < RANDOM_PIXELS / 3)
            begin
                idle_mode <= IDLE_MOSTLY_RX;
            end
            else if (random_sent < 2 * RANDOM_PIXELS / 3)
            begin
                idle_mode <= IDLE_MOSTLY_TX;
            end
            else
            begin
                idle_mode <= IDLE_NONE;
            end

            pick = $urandom_range(0, 19);
            if (pick == 0)
            begin
                w     = $urandom_range(0, 1) ? 1024 : $urandom_range(1025, 2047);
                h     = $urandom_range(4096, 8191);
                f     = $urandom_range(0, 1);
                count = 40;
            end
            else if (pick == 1)
            begin
                w     = $urandom_range(16, 20);
                h     = $urandom_range(16, 17);
                f     = $urandom_range(0, 1) ? 16 : $urandom_range(17, 31);
                count = w * h;
            end
            else if (pick == 2)
            begin
                f = $urandom_range(2, 8);
                if ($urandom_range(0, 1))
                begin
                    w = $urandom_range(1, f - 1);
                    h = $urandom_range(1, 12);
                end
                else
                begin
                    w = $urandom_range(1, 12);
                    h = $urandom_range(1, f - 1);
                end
                count = $urandom_range(20, 40);
            end
            else if (pick == 3)
            begin
                w     = 1;
                h     = $urandom_range(1, 5);
                f     = 1;
                count = 3 * h;
            end
            else
            begin
                w = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 24);
                h = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 12);
                f = ($urandom_range(0, 19) == 0) ? $urandom_range(5, 8) : $urandom_range(1, 4);
                frames = ((w + 1) * (h + 1) > 120) ? 1 : $urandom_range(1, 3);
                count  = frames * (w > 0 ? w : 1) * (h > 0 ? h : 1) + $urandom_range(0, 4);
            end

            program_frame(w, h, f);
            for (int i = 0; i < count; i++)
            begin
                if ($urandom_range(0, 299) == 0)
                begin
                    restart_write();
                end
                else if ($urandom_range(0, 249) == 0)
                begin
                    settle();
                end
                send_pixel(make_pixel(rand_channel(), rand_channel(), rand_channel()));
            end
            random_sent += count;
        end

        settle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0 && results_owed == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
